>>> rtl/key_press_classifier_volume_unit_defines.svh
// Assertion macros for the key press classifier.
`ifndef KEY_PRESS_CLASSIFIER_VOLUME_UNIT_DEFINES_SVH
`define KEY_PRESS_CLASSIFIER_VOLUME_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define KPCV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("kpcv assertion failed");
`define KPCV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("kpcv assertion failed");
`else
`define KPCV_ASSERT(lbl, clk, rstn, prop)
`define KPCV_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/kpcv_pkg.sv
package kpcv_pkg;

  localparam int unsigned TickW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned VolW    = 7;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT     = 1'd1;

  localparam logic [CfgW-1:0] LONG_PRESS_RESET = 16'd50;
  localparam logic [CfgW-1:0] REPEAT_RESET     = 16'd20;

  localparam logic [VolW-1:0] VOLUME_MAX   = 7'd100;
  localparam logic [VolW-1:0] VOLUME_RESET = 7'd50;

  localparam int unsigned KeyDownBit = 1;
  localparam int unsigned KeyModeBit = 2;
  localparam int unsigned KeyUpBit   = 3;

  typedef enum logic [2:0] {
    EVT_NONE     = 3'd0,
    EVT_PRESSED  = 3'd1,
    EVT_LONG     = 3'd2,
    EVT_CLICKED  = 3'd3,
    EVT_RELEASED = 3'd4
  } key_evt_e;

  typedef struct packed {
    logic [7:0]       key_bits;
    logic [TickW-1:0] tick_stamp;
  } kpcv_in_t;

  typedef struct packed {
    logic [2:0]      down_key_event;
    logic [2:0]      mode_key_event;
    logic [2:0]      up_key_event;
    logic [VolW-1:0] volume_level;
    logic            volume_changed;
  } kpcv_out_t;

  typedef struct packed {
    logic [CfgW-1:0] long_press_ticks;
    logic [CfgW-1:0] repeat_ticks;
  } kpcv_cfg_t;

endpackage

>>> rtl/key_press_classifier_volume_unit.sv
// One request is one poll of the key byte with its tick count and yields exactly one result.
// A poll enters the input register, is classified by compare logic against the stored hold
// state of keys 1, 2 and 3, and moves into the result register once that register is empty
// or its result is being taken; a new poll is taken every cycle while results are being taken.
// The 32-bit elapsed-tick subtract and compare of each key sets the cycle time. The user must
// write registers through the configuration port only while no poll is in flight; the block
// itself does not enforce this, and there is no start-up sweep.
`include "key_press_classifier_volume_unit_defines.svh"
module key_press_classifier_volume_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  kpcv_pkg::kpcv_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output kpcv_pkg::kpcv_out_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [kpcv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kpcv_pkg::CfgW-1:0]     cfg_data_i
);
  import kpcv_pkg::*;

  kpcv_cfg_t       cfg_q;
  kpcv_in_t        in_q;
  logic            in_valid_q;
  kpcv_out_t       out_q, out_d;
  logic            out_valid_q;
  logic            advance;
  key_evt_e        down_evt, mode_evt, up_evt;
  logic [VolW-1:0] level;
  logic            changed;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks <= LONG_PRESS_RESET;
      cfg_q.repeat_ticks     <= REPEAT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data_i;
        CFG_REPEAT:     cfg_q.repeat_ticks     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  kpcv_key_unit u_key_down (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .rep_en_i (1'b1),
    .down_i   (!in_q.key_bits[KeyDownBit]),
    .now_i    (in_q.tick_stamp),
    .cfg_i    (cfg_q),
    .evt_o    (down_evt)
  );

  kpcv_key_unit u_key_mode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .rep_en_i (1'b0),
    .down_i   (!in_q.key_bits[KeyModeBit]),
    .now_i    (in_q.tick_stamp),
    .cfg_i    (cfg_q),
    .evt_o    (mode_evt)
  );

  kpcv_key_unit u_key_up (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .rep_en_i (1'b1),
    .down_i   (!in_q.key_bits[KeyUpBit]),
    .now_i    (in_q.tick_stamp),
    .cfg_i    (cfg_q),
    .evt_o    (up_evt)
  );

  kpcv_volume u_volume (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .down_evt_i (down_evt),
    .up_evt_i   (up_evt),
    .level_o    (level),
    .changed_o  (changed)
  );

  always_comb begin
    out_d.down_key_event = down_evt;
    out_d.mode_key_event = mode_evt;
    out_d.up_key_event   = up_evt;
    out_d.volume_level   = level;
    out_d.volume_changed = changed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `KPCV_ASSERT(a_vol_range, clk_i, rst_ni,
               out_valid_q |-> (out_q.volume_level <= VOLUME_MAX))
  `KPCV_ASSERT(a_vol_cause, clk_i, rst_ni,
               (out_valid_q && out_q.volume_changed) |->
               ((out_q.down_key_event == EVT_CLICKED) || (out_q.down_key_event == EVT_LONG) ||
                (out_q.up_key_event == EVT_CLICKED) || (out_q.up_key_event == EVT_LONG)))
  `KPCV_ASSERT(a_adv_out, clk_i, rst_ni, advance |=> out_valid_q)
  `KPCV_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> (!out_valid_q && !in_valid_q))

endmodule

>>> rtl/kpcv_key_unit.sv
module kpcv_key_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     rep_en_i,
  input  logic                     down_i,
  input  logic [kpcv_pkg::TickW-1:0] now_i,
  input  kpcv_pkg::kpcv_cfg_t      cfg_i,
  output kpcv_pkg::key_evt_e       evt_o
);
  import kpcv_pkg::*;

  logic             was_q, was_d;
  logic             long_q, long_d;
  logic [TickW-1:0] start_q, start_d;
  logic [TickW-1:0] rep_q, rep_d;
  logic             first;
  logic [TickW-1:0] held, since_rep;

  always_comb begin
    first     = down_i && !was_q;
    start_d   = first ? now_i : start_q;
    long_d    = first ? 1'b0 : long_q;
    rep_d     = first ? '0 : rep_q;
    was_d     = down_i;
    evt_o     = first ? EVT_PRESSED : EVT_NONE;
    held      = now_i - start_d;
    since_rep = now_i - rep_d;
    if (down_i) begin
      if (!long_d) begin
        if (held >= TickW'(cfg_i.long_press_ticks)) begin
          evt_o  = EVT_LONG;
          long_d = 1'b1;
          if (rep_en_i) begin
            rep_d = now_i;
          end
        end
      end else if (rep_en_i) begin
        if (since_rep >= TickW'(cfg_i.repeat_ticks)) begin
          evt_o = EVT_LONG;
          rep_d = now_i;
        end
      end
    end
    if (!down_i && was_q) begin
      evt_o = long_q ? EVT_RELEASED : EVT_CLICKED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_q   <= 1'b0;
      long_q  <= 1'b0;
      start_q <= '0;
      rep_q   <= '0;
    end else if (en_i) begin
      was_q   <= was_d;
      long_q  <= long_d;
      start_q <= start_d;
      rep_q   <= rep_d;
    end
  end

endmodule

>>> rtl/kpcv_volume.sv
module kpcv_volume (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  kpcv_pkg::key_evt_e        down_evt_i,
  input  kpcv_pkg::key_evt_e        up_evt_i,
  output logic [kpcv_pkg::VolW-1:0] level_o,
  output logic                      changed_o
);
  import kpcv_pkg::*;

  logic [VolW-1:0] vol_q, vol_d, vol_mid;

  always_comb begin
    vol_mid = vol_q;
    if (down_evt_i == EVT_CLICKED || down_evt_i == EVT_LONG) begin
      if (vol_q > VOLUME_MAX) begin
        vol_mid = VOLUME_MAX;
      end else if (vol_q != '0) begin
        vol_mid = vol_q - VolW'(1);
      end
    end
    vol_d = vol_mid;
    if (up_evt_i == EVT_CLICKED || up_evt_i == EVT_LONG) begin
      if (vol_mid < VOLUME_MAX) begin
        vol_d = vol_mid + VolW'(1);
      end else begin
        vol_d = VOLUME_MAX;
      end
    end
    level_o   = vol_d;
    changed_o = (vol_d != vol_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q <= VOLUME_RESET;
    end else if (en_i) begin
      vol_q <= vol_d;
    end
  end

endmodule
